// ----- hw/rtl/kfi_pkg.sv -----
// Shared types, constants and command codes for the keyframe track interpolator.
`default_nettype none
package kfi_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int IDX_W     = $clog2(MAX_KEYS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int FRAC_BITS = 16;
	localparam int F_W       = FRAC_BITS + 1;

	// Request types
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic CFG_KEY_COUNT  = 1'b0;
	localparam logic CFG_TRACK_MODE = 1'b1;

	// Datapath operation codes issued by the controller
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 4'd1;
	localparam logic [OP_W-1:0] OP_QRY   = 4'd2;
	localparam logic [OP_W-1:0] OP_T0    = 4'd3;
	localparam logic [OP_W-1:0] OP_TL    = 4'd4;
	localparam logic [OP_W-1:0] OP_SM    = 4'd5;
	localparam logic [OP_W-1:0] OP_SM1   = 4'd6;
	localparam logic [OP_W-1:0] OP_SA    = 4'd7;
	localparam logic [OP_W-1:0] OP_SB    = 4'd8;
	localparam logic [OP_W-1:0] OP_DS    = 4'd9;
	localparam logic [OP_W-1:0] OP_MX    = 4'd10;
	localparam logic [OP_W-1:0] OP_MY    = 4'd11;
	localparam logic [OP_W-1:0] OP_MZ    = 4'd12;
	localparam logic [OP_W-1:0] OP_AZ    = 4'd13;

	typedef struct packed {
		logic              req_type;
		logic [IDX_W-1:0]  key_index;
		logic [31:0]       key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]       query_time;
	} kfi_req_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [IDX_W-1:0]   segment;
	} kfi_res_t;

	typedef struct packed {
		logic [31:0]        t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} key_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic ramp;
		logic ramp_full;
		logic last;
		logic search_done;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kfi_div.sv -----
// Restoring divider producing the unsigned interpolation fraction, one bit a cycle.
`default_nettype none
module kfi_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [31:0]         num,
	input  wire logic [31:0]         den,
	output logic                     done,
	output logic [kfi_pkg::F_W-1:0]  quo
);
	import kfi_pkg::*;

	localparam int STEP_W = $clog2(FRAC_BITS + 1);

	logic              run_q;
	logic [STEP_W-1:0] cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic              zero_q;
	logic [F_W-1:0]    quo_q;
	logic [32:0]       rem2;
	logic              fits;

	assign rem2 = {rem_q, 1'b0};
	assign fits = rem2 >= {1'b0, den_q};

	// Control: step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= STEP_W'(FRAC_BITS);
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath: a numerator at or above a nonzero divisor gives exactly one; a zero divisor gives zero.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			zero_q <= (den == '0);
			if (num >= den) begin
				rem_q <= '0;
				quo_q <= F_W'(1);
			end else begin
				rem_q <= num;
				quo_q <= '0;
			end
		end else if (run_q && (cnt_q != '0)) begin
			rem_q <= fits ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
			quo_q <= {quo_q[F_W-2:0], fits};
		end
	end

	assign done = run_q && (cnt_q == '0);
	assign quo  = zero_q ? '0 : quo_q;

endmodule
`default_nettype wire

// ----- hw/rtl/kfi_datapath.sv -----
// Key store, search registers, fraction divider and shared interpolation multiplier.
`default_nettype none
module kfi_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire kfi_pkg::cmd_t    cmd,
	input  wire kfi_pkg::kfi_req_t req,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [6:0]       cfg_wdata,
	output kfi_pkg::status_t      status,
	output kfi_pkg::kfi_res_t     res
);
	import kfi_pkg::*;

	localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
	localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;
	localparam logic signed [31:0] VAL_ONE = 32'sd1 <<< FRAC_BITS;

	key_t               mem [MAX_KEYS];
	key_t               rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic [CNT_W-1:0]   kc_q;
	logic               mode_q;
	logic [CNT_W-1:0]   n;
	logic [IDX_W-1:0]   last_idx;

	logic [31:0]        q_q;
	logic [31:0]        tm_q;
	logic [31:0]        t0s_q;
	logic [31:0]        num_q;
	logic [31:0]        den_q;
	logic [IDX_W-1:0]   lo_q;
	logic [IDX_W-1:0]   hi_q;
	logic [IDX_W-1:0]   seg_q;
	logic [F_W-1:0]     f_q;
	key_t               a_q;
	key_t               b_q;
	logic signed [50:0] prod_s1;
	logic signed [31:0] ox_q;
	logic signed [31:0] oy_q;
	logic signed [31:0] oz_q;

	logic [IDX_W-1:0]   mid;
	logic [IDX_W-1:0]   lo_n;
	logic [IDX_W-1:0]   hi_n;
	logic [IDX_W-1:0]   mid_n;
	logic [IDX_W-1:0]   seg_n;
	logic               found;
	logic               go_left;
	logic               ended;

	logic               div_done;
	logic [F_W-1:0]     div_quo;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [32:0] diff;
	logic signed [31:0] add_a;
	logic signed [51:0] sum;
	logic signed [31:0] sat_val;

	// Effective key count, held within one and the store depth
	always_comb begin
		if (kc_q == '0) begin
			n = CNT_W'(1);
		end else if (kc_q > CNT_W'(MAX_KEYS)) begin
			n = CNT_W'(MAX_KEYS);
		end else begin
			n = kc_q;
		end
	end
	assign last_idx = IDX_W'(n - 1'b1);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kc_q   <= CNT_W'(1);
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_COUNT:  kc_q   <= cfg_wdata[CNT_W-1:0];
				CFG_TRACK_MODE: mode_q <= cfg_wdata[0];
				default:        kc_q   <= kc_q;
			endcase
		end
	end

	// Binary search step decision on the pair t[mid], t[mid+1]
	assign mid     = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
	assign found   = (tm_q <= q_q) && (q_q <= rd_q.t);
	assign go_left = tm_q > q_q;
	assign lo_n    = go_left ? lo_q : mid;
	assign hi_n    = go_left ? mid : hi_q;
	assign mid_n   = IDX_W'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
	assign ended   = found || (lo_n >= hi_n) || (!go_left && (mid == lo_q));
	assign seg_n   = found ? mid : lo_n;

	// Read address for the next beat of the key store
	always_comb begin
		case (cmd.op)
			OP_QRY:  rd_addr = '0;
			OP_T0:   rd_addr = last_idx;
			OP_TL:   rd_addr = last_idx >> 1;
			OP_SM:   rd_addr = mid + 1'b1;
			OP_SM1:  rd_addr = ended ? seg_n : mid_n;
			OP_SA:   rd_addr = seg_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	// Key store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			mem[req.key_index] <= '{t: req.key_time, x: req.key_x,
				y: req.key_y, z: req.key_z};
		end
		rd_q <= mem[rd_addr];
	end

	// Status back to the controller
	assign status.ramp        = q_q <= rd_q.t;
	assign status.ramp_full   = (rd_q.t == '0) || (q_q == rd_q.t);
	assign status.last        = q_q >= rd_q.t;
	assign status.search_done = ended;
	assign status.div_done    = div_done;

	kfi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DS),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Query sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			case (cmd.op)
				OP_TL: begin
					lo_q <= '0;
					hi_q <= last_idx;
				end
				OP_SM1: begin
					lo_q <= lo_n;
					hi_q <= hi_n;
				end
				default: begin
					lo_q <= lo_q;
				end
			endcase
		end
	end

	// Operand capture along the query
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_QRY: begin
				q_q <= req.query_time;
			end
			OP_T0: begin
				a_q   <= '{t: '0, x: mode_q ? VAL_ONE : '0,
					y: mode_q ? VAL_ONE : '0, z: mode_q ? VAL_ONE : '0};
				b_q   <= rd_q;
				seg_q <= '0;
				num_q <= q_q;
				den_q <= rd_q.t;
				f_q   <= F_W'(1) << FRAC_BITS;
			end
			OP_TL: begin
				a_q   <= rd_q;
				b_q   <= rd_q;
				seg_q <= last_idx;
				f_q   <= '0;
			end
			OP_SM: begin
				tm_q <= rd_q.t;
			end
			OP_SM1: begin
				seg_q <= seg_n;
			end
			OP_SA: begin
				a_q   <= rd_q;
				t0s_q <= rd_q.t;
			end
			OP_SB: begin
				b_q   <= rd_q;
				num_q <= (q_q >= t0s_q) ? q_q - t0s_q : '0;
				den_q <= (rd_q.t > t0s_q) ? rd_q.t - t0s_q : '0;
			end
			default: begin
				if (div_done) begin
					f_q <= div_quo;
				end
			end
		endcase
	end

	// Shared multiplier: one component a cycle, product registered
	always_comb begin
		case (cmd.op)
			OP_MY: begin
				mul_a = a_q.y;
				mul_b = b_q.y;
				add_a = a_q.x;
			end
			OP_MZ: begin
				mul_a = a_q.z;
				mul_b = b_q.z;
				add_a = a_q.y;
			end
			OP_AZ: begin
				mul_a = a_q.z;
				mul_b = b_q.z;
				add_a = a_q.z;
			end
			default: begin
				mul_a = a_q.x;
				mul_b = b_q.x;
				add_a = a_q.x;
			end
		endcase
	end

	assign diff = 33'(mul_b) - 33'(mul_a);

	// Floor shift of the product, add of the start value, then saturation
	assign sum = 52'(add_a) + 52'(prod_s1 >>> FRAC_BITS);
	always_comb begin
		if (sum > SAT_MAX) begin
			sat_val = 32'sh7FFFFFFF;
		end else if (sum < SAT_MIN) begin
			sat_val = 32'sh80000000;
		end else begin
			sat_val = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == OP_MX) || (cmd.op == OP_MY) || (cmd.op == OP_MZ)) begin
			prod_s1 <= 51'(diff * $signed({1'b0, f_q}));
		end
		case (cmd.op)
			OP_MY:   ox_q <= sat_val;
			OP_MZ:   oy_q <= sat_val;
			OP_AZ:   oz_q <= sat_val;
			default: ox_q <= ox_q;
		endcase
	end

	assign res = '{out_x: ox_q, out_y: oy_q, out_z: oz_q, segment: seg_q};

endmodule
`default_nettype wire

// ----- hw/rtl/kfi_ctrl.sv -----
// Controller state machine sequencing key writes and queries through the datapath.
`default_nettype none
module kfi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              req_type,
	input  wire kfi_pkg::status_t  status,
	output kfi_pkg::cmd_t          cmd,
	output logic                   busy,
	output logic                   done
);
	import kfi_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_T0   = 4'd1;
	localparam logic [3:0] S_TL   = 4'd2;
	localparam logic [3:0] S_SM   = 4'd3;
	localparam logic [3:0] S_SM1  = 4'd4;
	localparam logic [3:0] S_SA   = 4'd5;
	localparam logic [3:0] S_SB   = 4'd6;
	localparam logic [3:0] S_DS   = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_MX   = 4'd9;
	localparam logic [3:0] S_MY   = 4'd10;
	localparam logic [3:0] S_MZ   = 4'd11;
	localparam logic [3:0] S_AZ   = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_n;

	// Next state and command
	always_comb begin
		state_n = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_WRITE) begin
						cmd.op = OP_WRITE;
					end else begin
						cmd.op  = OP_QRY;
						state_n = S_T0;
					end
				end
			end
			S_T0: begin
				cmd.op = OP_T0;
				if (status.ramp) begin
					state_n = status.ramp_full ? S_MX : S_DS;
				end else begin
					state_n = S_TL;
				end
			end
			S_TL: begin
				cmd.op  = OP_TL;
				state_n = status.last ? S_MX : S_SM;
			end
			S_SM: begin
				cmd.op  = OP_SM;
				state_n = S_SM1;
			end
			S_SM1: begin
				cmd.op  = OP_SM1;
				state_n = status.search_done ? S_SA : S_SM;
			end
			S_SA: begin
				cmd.op  = OP_SA;
				state_n = S_SB;
			end
			S_SB: begin
				cmd.op  = OP_SB;
				state_n = S_DS;
			end
			S_DS: begin
				cmd.op  = OP_DS;
				state_n = S_DIV;
			end
			S_DIV: begin
				if (status.div_done) begin
					state_n = S_MX;
				end
			end
			S_MX: begin
				cmd.op  = OP_MX;
				state_n = S_MY;
			end
			S_MY: begin
				cmd.op  = OP_MY;
				state_n = S_MZ;
			end
			S_MZ: begin
				cmd.op  = OP_MZ;
				state_n = S_AZ;
			end
			S_AZ: begin
				cmd.op  = OP_AZ;
				state_n = S_OUT;
			end
			S_OUT: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

	// A result beat only ever closes a query.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a query");

	// The strobe lasts a single cycle and the block is free straight after.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy)) else $error("result strobe not a single beat");

	// A key write completes in the cycle it is taken.
	a_write_one: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_WRITE)) |=> !busy)
		else $error("key write held the block busy");

	// A query always occupies the block on the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == REQ_QUERY)) |=> busy)
		else $error("query not taken up");

endmodule
`default_nettype wire

// ----- hw/rtl/keyframe_track_interpolator.sv -----
// Top level of the keyframe track interpolator. A key write completes in the cycle it is
// taken and gives no beat. A query at key 0 (or with key 0 at time zero) or at or after the
// last key needs no division; one before key 0, or between keys after a binary search,
// runs the 16-step fraction divider. Keys are read through the single key store read port;
// the next request is taken after the result beat. Reset clears the controller and
// configuration registers (key_count 1, position mode); keys are undefined until written.
// The receiver cannot stall the result beat.
`default_nettype none
module keyframe_track_interpolator (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire kfi_pkg::kfi_req_t req,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [6:0]        cfg_wdata,
	output logic                   done,
	output kfi_pkg::kfi_res_t      res
);
	import kfi_pkg::*;

	cmd_t    cmd;
	status_t status;

	kfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	kfi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.res       (res)
	);

endmodule
`default_nettype wire
